@@ sv/psar_pkg.sv @@
// ----------------------------------------------------------------------------
// psar_pkg
// Shared types and codes of the scroll and address register unit.
// ----------------------------------------------------------------------------
package psar_pkg;

  typedef enum logic [3:0] {
    OP_CTRL   = 4'd0,
    OP_SCROLL = 4'd1,
    OP_ADDR   = 4'd2,
    OP_STATUS = 4'd3,
    OP_DATA   = 4'd4,
    OP_INC_X  = 4'd5,
    OP_INC_Y  = 4'd6,
    OP_COPY_X = 4'd7,
    OP_COPY_Y = 4'd8
  } op_t;

  localparam logic [4:0] COARSE_MAX = 5'd31;
  localparam logic [4:0] ROW_LAST   = 5'd29;
  localparam logic [2:0] FINE_MAX   = 3'd7;

  typedef struct packed {
    logic [14:0] cur_addr;
    logic [14:0] tmp_addr;
    logic [2:0]  fine_scroll;
    logic        toggle;
    logic        step32;
  } scroll_state_t;

  typedef struct packed {
    logic [14:0] vram_addr;
    logic [13:0] access_addr;
    logic [2:0]  fine_x;
    logic        write_toggle;
    logic [13:0] nt_fetch_addr;
    logic [13:0] at_fetch_addr;
    logic [2:0]  at_shift;
  } result_t;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] data_byte;
  } item_t;

endpackage

@@ sv/ppu_scroll_address_registers.sv @@
// ----------------------------------------------------------------------------
// ppu_scroll_address_registers
// Video address and scroll registers (v, t, fine x, write toggle).
//
//   channel  handshake            payload
//   input    in_valid/in_ready    op, data_byte
//   output   out_valid/out_ready  vram_addr .. at_shift
//
// One operation per cycle while the output is not stalled; an operation passes
// through the input register, then its update is written into the result
// register. State updates when an operation moves from the input register
// into the result register. Reset clears v, t, x, w and the increment mode.
// A stalled output holds its result; the input register still takes one
// more operation behind it.
// ----------------------------------------------------------------------------
module ppu_scroll_address_registers
  import psar_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  op,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] vram_addr,
  output logic [13:0] access_addr,
  output logic [2:0]  fine_x,
  output logic        write_toggle,
  output logic [13:0] nt_fetch_addr,
  output logic [13:0] at_fetch_addr,
  output logic [2:0]  at_shift
);

  item_t         item_in;
  item_t         item_q;
  logic          held_valid;
  logic          out_free;
  logic          advance;
  scroll_state_t state;
  scroll_state_t state_next;
  result_t       result_d;
  result_t       result_q;

  assign item_in = '{op: op, data_byte: data_byte};
  assign advance = held_valid && out_free;

  psar_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item_in    (item_in),
    .advance    (advance),
    .held_valid (held_valid),
    .item_q     (item_q)
  );

  psar_update u_update (
    .state      (state),
    .item       (item_q),
    .state_next (state_next),
    .result     (result_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  psar_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result_in (result_d),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (out_free),
    .result_q  (result_q)
  );

  assign vram_addr     = result_q.vram_addr;
  assign access_addr   = result_q.access_addr;
  assign fine_x        = result_q.fine_x;
  assign write_toggle  = result_q.write_toggle;
  assign nt_fetch_addr = result_q.nt_fetch_addr;
  assign at_fetch_addr = result_q.at_fetch_addr;
  assign at_shift      = result_q.at_shift;

endmodule

@@ sv/psar_in_stage.sv @@
// ----------------------------------------------------------------------------
// psar_in_stage
// Input register: holds one operation until the update logic takes it.
// ----------------------------------------------------------------------------
module psar_in_stage
  import psar_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t item_in,
  input  logic  advance,
  output logic  held_valid,
  output item_t item_q
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q <= item_in;
    end
  end

endmodule

@@ sv/psar_update.sv @@
// ----------------------------------------------------------------------------
// psar_update
// Next v/t/x/w state and result fields for one operation.
// ----------------------------------------------------------------------------
module psar_update
  import psar_pkg::*;
(
  input  scroll_state_t state,
  input  item_t         item,
  output scroll_state_t state_next,
  output result_t       result
);

  logic [7:0]  d;
  logic [14:0] cur;
  logic [14:0] tmp;
  logic [14:0] a;
  logic [4:0]  row;

  assign d   = item.data_byte;
  assign cur = state.cur_addr;
  assign tmp = state.tmp_addr;

  always_comb begin
    state_next = state;
    row = cur[9:5];
    unique case (op_t'(item.op))
      OP_CTRL: begin
        state_next.tmp_addr[11:10] = d[1:0];
        state_next.step32 = d[2];
      end
      OP_SCROLL: begin
        if (!state.toggle) begin
          state_next.tmp_addr[4:0] = d[7:3];
          state_next.fine_scroll = d[2:0];
          state_next.toggle = 1'b1;
        end else begin
          state_next.tmp_addr[14:12] = d[2:0];
          state_next.tmp_addr[9:5] = d[7:3];
          state_next.toggle = 1'b0;
        end
      end
      OP_ADDR: begin
        if (!state.toggle) begin
          state_next.tmp_addr[14:8] = {1'b0, d[5:0]};
          state_next.toggle = 1'b1;
        end else begin
          state_next.tmp_addr[7:0] = d;
          state_next.cur_addr = {tmp[14:8], d};
          state_next.toggle = 1'b0;
        end
      end
      OP_STATUS: begin
        state_next.toggle = 1'b0;
      end
      OP_DATA: begin
        state_next.cur_addr = cur + (state.step32 ? 15'd32 : 15'd1);
      end
      OP_INC_X: begin
        if (cur[4:0] == COARSE_MAX) begin
          state_next.cur_addr[4:0] = 5'd0;
          state_next.cur_addr[10] = !cur[10];
        end else begin
          state_next.cur_addr[4:0] = cur[4:0] + 5'd1;
        end
      end
      OP_INC_Y: begin
        if (cur[14:12] != FINE_MAX) begin
          state_next.cur_addr[14:12] = cur[14:12] + 3'd1;
        end else begin
          state_next.cur_addr[14:12] = 3'd0;
          if (cur[9:5] == ROW_LAST) begin
            row = 5'd0;
            state_next.cur_addr[11] = !cur[11];
          end else if (cur[9:5] == COARSE_MAX) begin
            row = 5'd0;
          end else begin
            row = cur[9:5] + 5'd1;
          end
          state_next.cur_addr[9:5] = row;
        end
      end
      OP_COPY_X: begin
        state_next.cur_addr[10] = tmp[10];
        state_next.cur_addr[4:0] = tmp[4:0];
      end
      OP_COPY_Y: begin
        state_next.cur_addr[14:11] = tmp[14:11];
        state_next.cur_addr[9:5] = tmp[9:5];
      end
      default: begin
      end
    endcase
  end

  assign a = state_next.cur_addr;

  always_comb begin
    result.vram_addr     = a;
    result.access_addr   = cur[13:0];
    result.fine_x        = state_next.fine_scroll;
    result.write_toggle  = state_next.toggle;
    result.nt_fetch_addr = {2'b10, a[11:0]};
    result.at_fetch_addr = {2'b10, a[11:10], 4'b1111, a[9:7], a[4:2]};
    result.at_shift      = {a[6], a[1], 1'b0};
  end

endmodule

@@ sv/psar_out_stage.sv @@
// ----------------------------------------------------------------------------
// psar_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module psar_out_stage
  import psar_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result_in,
  input  logic    out_ready,
  output logic    out_valid,
  output logic    free,
  output result_t result_q
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_q <= result_in;
    end
  end

endmodule

@@ sv/psar_checker.sv @@
// ----------------------------------------------------------------------------
// psar_checker
// Port-level checks of the scroll and address register unit.
// ----------------------------------------------------------------------------
module psar_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] vram_addr,
  input logic [13:0] access_addr,
  input logic [13:0] nt_fetch_addr,
  input logic [13:0] at_fetch_addr,
  input logic [2:0]  at_shift
);

  logic        have_prev;
  logic [14:0] prev_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      prev_addr <= '0;
    end else if (out_valid && out_ready) begin
      have_prev <= 1'b1;
      prev_addr <= vram_addr;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(vram_addr) && $stable(access_addr))
    else $error("stalled result changed");

  // access address of a result is the address left by the previous transfer
  a_chain: assert property (@(posedge clk) disable iff (rst)
    out_valid && have_prev |-> access_addr == prev_addr[13:0])
    else $error("access address breaks the address chain");

  a_nt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> nt_fetch_addr == {2'b10, vram_addr[11:0]})
    else $error("nametable fetch address mismatch");

  a_at: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> at_fetch_addr == {2'b10, vram_addr[11:10], 4'b1111, vram_addr[9:7],
                                    vram_addr[4:2]}
                  && at_shift == {vram_addr[6], vram_addr[1], 1'b0})
    else $error("attribute fetch mismatch");

endmodule

bind ppu_scroll_address_registers psar_checker u_psar_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .vram_addr     (vram_addr),
  .access_addr   (access_addr),
  .nt_fetch_addr (nt_fetch_addr),
  .at_fetch_addr (at_fetch_addr),
  .at_shift      (at_shift)
);

@@ test/ppu_scroll_address_registers_tb.sv @@
// ----------------------------------------------------------------------------
// ppu_scroll_address_registers_tb
// Self-checking bench for the video address and scroll registers. A local
// model of v, t, fine x, the write toggle and the increment mode predicts
// every result. Directed tests cover the coarse X, row 29 and row 31 wraps,
// the 15-bit wrap of the data access and the unused op codes. Random phases
// then run scroll and address write pairs, data access runs and rendering
// bursts, with and without idle cycles on both handshakes.
// ----------------------------------------------------------------------------
module ppu_scroll_address_registers_tb;
  import psar_pkg::*;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          PHASE_ITEMS    = 210;
  localparam logic [3:0]  OP_UNUSED_LO   = 4'd9;
  localparam logic [3:0]  OP_UNUSED_HI   = 4'd15;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  op;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [14:0] vram_addr;
  logic [13:0] access_addr;
  logic [2:0]  fine_x;
  logic        write_toggle;
  logic [13:0] nt_fetch_addr;
  logic [13:0] at_fetch_addr;
  logic [2:0]  at_shift;

  // model state
  logic [14:0] v_addr;
  logic [14:0] t_addr;
  logic [2:0]  fine_scroll;
  logic        toggle;
  logic        step32;

  result_t pending_results[$];

  int send_idle_pct;
  int recv_stall_pct;
  int n_items;
  int n_results;
  int n_errors;
  int n_x_wraps;
  int n_row29_wraps;
  int n_row31_wraps;
  int quiet_cycles;

  ppu_scroll_address_registers u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .vram_addr    (vram_addr),
    .access_addr  (access_addr),
    .fine_x       (fine_x),
    .write_toggle (write_toggle),
    .nt_fetch_addr(nt_fetch_addr),
    .at_fetch_addr(at_fetch_addr),
    .at_shift     (at_shift)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t advance_scroll_regs(logic [3:0] code, logic [7:0] d);
    result_t     r;
    logic [14:0] prior;
    prior = v_addr;
    case (op_t'(code))
      OP_CTRL: begin
        t_addr[11:10] = d[1:0];
        step32 = d[2];
      end
      OP_SCROLL: begin
        if (!toggle) begin
          t_addr[4:0] = d[7:3];
          fine_scroll = d[2:0];
        end else begin
          t_addr[14:12] = d[2:0];
          t_addr[9:5] = d[7:3];
        end
        toggle = ~toggle;
      end
      OP_ADDR: begin
        if (!toggle) begin
          t_addr[14:8] = {1'b0, d[5:0]};
        end else begin
          t_addr[7:0] = d;
          v_addr = t_addr;
        end
        toggle = ~toggle;
      end
      OP_STATUS: toggle = 1'b0;
      OP_DATA: v_addr = v_addr + (step32 ? 15'd32 : 15'd1);
      OP_INC_X: begin
        if (v_addr[4:0] == COARSE_MAX) begin
          v_addr[4:0] = '0;
          v_addr[10] = ~v_addr[10];
          n_x_wraps++;
        end else begin
          v_addr[4:0] = v_addr[4:0] + 5'd1;
        end
      end
      OP_INC_Y: begin
        if (v_addr[14:12] != FINE_MAX) begin
          v_addr[14:12] = v_addr[14:12] + 3'd1;
        end else begin
          v_addr[14:12] = '0;
          if (v_addr[9:5] == ROW_LAST) begin
            v_addr[9:5] = '0;
            v_addr[11] = ~v_addr[11];
            n_row29_wraps++;
          end else if (v_addr[9:5] == COARSE_MAX) begin
            v_addr[9:5] = '0;
            n_row31_wraps++;
          end else begin
            v_addr[9:5] = v_addr[9:5] + 5'd1;
          end
        end
      end
      OP_COPY_X: begin
        v_addr[10] = t_addr[10];
        v_addr[4:0] = t_addr[4:0];
      end
      OP_COPY_Y: begin
        v_addr[14:11] = t_addr[14:11];
        v_addr[9:5] = t_addr[9:5];
      end
      default: ;
    endcase
    r.vram_addr     = v_addr;
    r.access_addr   = prior[13:0];
    r.fine_x        = fine_scroll;
    r.write_toggle  = toggle;
    r.nt_fetch_addr = {2'b10, v_addr[11:0]};
    r.at_fetch_addr = {2'b10, v_addr[11:10], 4'b1111, v_addr[9:7], v_addr[4:2]};
    r.at_shift      = {v_addr[6], v_addr[1], 1'b0};
    return r;
  endfunction

  task automatic send_op(input logic [3:0] code, input logic [7:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    op        <= code;
    data_byte <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(advance_scroll_regs(code, d));
    n_items++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
    if (exp_val !== act_val) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
               act_val);
    end
  endtask

  // result checker and transfer activity for the watchdog
  initial begin
    result_t want;
    forever begin
      @(posedge clk);
      if (!rst && ((in_valid && in_ready) || (out_valid && out_ready)))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (!rst && out_valid && out_ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result, expected none, actual vram_addr %0h", $time,
                   vram_addr);
        end else begin
          want = pending_results.pop_front();
          compare_field("vram_addr", 16'(want.vram_addr), 16'(vram_addr));
          compare_field("access_addr", 16'(want.access_addr), 16'(access_addr));
          compare_field("fine_x", 16'(want.fine_x), 16'(fine_x));
          compare_field("write_toggle", 16'(want.write_toggle), 16'(write_toggle));
          compare_field("nt_fetch_addr", 16'(want.nt_fetch_addr), 16'(nt_fetch_addr));
          compare_field("at_fetch_addr", 16'(want.at_fetch_addr), 16'(at_fetch_addr));
          compare_field("at_shift", 16'(want.at_shift), 16'(at_shift));
        end
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("%0t: watchdog expired, %0d results outstanding", $time,
             pending_results.size());
    $display("FAIL");
    $finish;
  end

  // max scroll values, coarse X wrap, row 31 wrap, 15-bit access wrap
  task automatic test_scroll_extremes();
    send_op(OP_CTRL, 8'h03);
    send_op(OP_SCROLL, 8'hFF);
    send_op(OP_SCROLL, 8'hFF);
    send_op(OP_COPY_X, 8'h00);
    send_op(OP_COPY_Y, 8'hFF);
    send_op(OP_INC_X, 8'h00);
    send_op(OP_INC_Y, 8'h00);
    send_op(OP_DATA, 8'h00);
    send_op(OP_COPY_X, 8'h00);
    send_op(OP_COPY_Y, 8'h00);
    send_op(OP_DATA, 8'hFF);
  endtask

  // address pair, toggle clear by status read, increment by 32
  task automatic test_address_access();
    send_op(OP_CTRL, 8'h04);
    send_op(OP_ADDR, 8'hFF);
    send_op(OP_STATUS, 8'h00);
    send_op(OP_ADDR, 8'h3F);
    send_op(OP_ADDR, 8'hA0);
    send_op(OP_DATA, 8'h00);
  endtask

  // row 29 wrap with nametable flip, plain fine Y step, unused codes
  task automatic test_row_wrap();
    send_op(OP_SCROLL, 8'h00);
    send_op(OP_SCROLL, 8'hEF);
    send_op(OP_COPY_Y, 8'h00);
    send_op(OP_INC_Y, 8'h00);
    send_op(OP_INC_Y, 8'h00);
    send_op(OP_UNUSED_LO, 8'h55);
    send_op(OP_UNUSED_HI, 8'hAA);
    send_op(OP_CTRL, 8'h00);
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input int stall_pct);
    int         stop_at;
    int         burst;
    logic [7:0] d;
    stop_at        = n_items + count;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (n_items < stop_at) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          if ($urandom_range(3) == 0) send_op(OP_STATUS, 8'($urandom_range(255)));
          send_op(OP_SCROLL, 8'($urandom_range(255)));
          d = 8'($urandom_range(255));
          if ($urandom_range(1) == 0) d[2:0] = FINE_MAX;
          send_op(OP_SCROLL, d);
        end
        3, 4: begin
          if ($urandom_range(2) == 0) send_op(OP_CTRL, 8'($urandom_range(255)));
          send_op(OP_ADDR, 8'($urandom_range(255)));
          send_op(OP_ADDR, 8'($urandom_range(255)));
          repeat ($urandom_range(4)) send_op(OP_DATA, 8'($urandom_range(255)));
        end
        5, 6, 7: begin
          burst = $urandom_range(8, 2);
          repeat (burst) begin
            case ($urandom_range(7))
              0, 1, 2, 3: send_op(OP_INC_X, 8'($urandom_range(255)));
              4, 5:       send_op(OP_INC_Y, 8'($urandom_range(255)));
              6:          send_op(OP_COPY_X, 8'($urandom_range(255)));
              default:    send_op(OP_COPY_Y, 8'($urandom_range(255)));
            endcase
          end
        end
        8: send_op(OP_CTRL, 8'($urandom_range(255)));
        default: send_op(4'($urandom_range(15)), 8'($urandom_range(255)));
      endcase
    end
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    op             = '0;
    data_byte      = '0;
    v_addr         = '0;
    t_addr         = '0;
    fine_scroll    = '0;
    toggle         = 1'b0;
    step32         = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    n_items        = 0;
    n_results      = 0;
    n_errors       = 0;
    n_x_wraps      = 0;
    n_row29_wraps  = 0;
    n_row31_wraps  = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_scroll_extremes();
    test_address_access();
    test_row_wrap();
    wait_for_results();

    test_random_traffic(PHASE_ITEMS, 0, 0);
    wait_for_results();
    test_random_traffic(PHASE_ITEMS, 82, 0);
    test_random_traffic(PHASE_ITEMS, 0, 82);
    wait_for_results();
    test_random_traffic(PHASE_ITEMS, 28, 28);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_results.size() != 0) begin
      n_errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end
    $display("Ran %0d operations, checked %0d results over four handshake phases.",
             n_items, n_results);
    $display("Coarse X wraps %0d, row 29 wraps %0d, row 31 wraps %0d, mismatches %0d.",
             n_x_wraps, n_row29_wraps, n_row31_wraps, n_errors);
    if (n_errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
